>>> hdl/tdt_pkg.sv
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared types and constants for the touch drag tracker: event kinds, fixed
// field widths, reset values and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdt_pkg;

  // default table depth and coordinate width
  localparam int DEF_MAX_DRAGS  = 16;
  localparam int DEF_COORD_BITS = 12;

  // fixed field widths
  localparam int KIND_W  = 2;
  localparam int BTN_W   = 8;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;
  localparam int DIST_W  = 13;

  // reported distance saturates here, also used when the table is empty
  localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

  // max_distance after reset
  localparam logic [DIST_W-1:0] MAXD_RESET = DIST_W'(106);

  // event kinds
  typedef enum logic [KIND_W-1:0] {
    K_UPDATE = 2'd0,
    K_DROP   = 2'd1,
    K_SET_UI = 2'd2,
    K_CLEAR  = 2'd3
  } kind_t;

endpackage

>>> hdl/touch_drag_tracker_core.sv
// ----------------------------------------------------------------------------
// touch_drag_tracker_core
// Insertion-ordered table of touch drags with nearest-neighbor matching,
// compaction of released entries, ui flag marking and clear.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------
//   in_      | input     | in_valid / in_ready   | kind, prev/loc point, press, ui
//   out_     | output    | out_valid / out_ready | slot, flags, count, distance
//   cfg_     | input     | cfg_wr_en (no wait)   | max_distance
//
// An update, drop or set-ui transaction walks the held entries through one
// entry memory with a single read port, one entry per cycle; the result is
// registered through S_SCAN, S_FINISH (update only) and S_DONE. A clear, or an
// event on an empty table, skips the walk.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register, so the next transaction is taken while it stalls.
// Reset (rst_n, synchronous) empties the table; entries need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module touch_drag_tracker_core #(
  parameter int MAX_DRAGS  = tdt_pkg::DEF_MAX_DRAGS,
  parameter int COORD_BITS = tdt_pkg::DEF_COORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [tdt_pkg::DIST_W-1:0]  cfg_wr_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tdt_pkg::KIND_W-1:0]  in_kind,
  input  logic [COORD_BITS-1:0]       in_prev_x,
  input  logic [COORD_BITS-1:0]       in_prev_y,
  input  logic [COORD_BITS-1:0]       in_loc_x,
  input  logic [COORD_BITS-1:0]       in_loc_y,
  input  logic                        in_is_pressed,
  input  logic [tdt_pkg::BTN_W-1:0]   in_button_mask,
  input  logic                        in_ui_value,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tdt_pkg::SLOT_W-1:0]  out_slot,
  output logic                        out_created,
  output logic                        out_table_full,
  output logic [tdt_pkg::COUNT_W-1:0] out_entry_count,
  output logic [tdt_pkg::DIST_W-1:0]  out_best_distance
);

  import tdt_pkg::*;

  localparam int IW   = (MAX_DRAGS > 1) ? $clog2(MAX_DRAGS) : 1;
  localparam int CNTW = $clog2(MAX_DRAGS + 1);
  localparam int DW   = COORD_BITS + 1;
  localparam int CW   = (DW > DIST_W) ? DW : DIST_W;

  typedef struct packed {
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] last_x;
    logic [COORD_BITS-1:0] last_y;
    logic                  pressed;
    logic                  fresh;
    logic [BTN_W-1:0]      buttons;
    logic                  ui_flag;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_DONE
  } state_t;

  state_t state_r;

  // configuration register
  logic [DIST_W-1:0] max_distance_r;

  // latched transaction
  kind_t                 kind_r;
  logic [COORD_BITS-1:0] prev_x_r, prev_y_r, loc_x_r, loc_y_r;
  logic                  pressed_r;
  logic [BTN_W-1:0]      buttons_r;
  logic                  ui_value_r;

  // table state and walk control
  logic [CNTW-1:0] held_count_r;
  logic [CNTW-1:0] rd_idx_r;
  logic            pend_r;
  logic [IW-1:0]   pend_idx_r;
  logic [CNTW-1:0] keep_r;

  // nearest entry so far
  logic [DW-1:0] best_d_r;
  logic [IW-1:0] best_idx_r;
  entry_t        best_ent_r;

  // pending result
  logic [IW-1:0]     res_slot_r;
  logic              res_created_r;
  logic              res_full_r;
  logic [DIST_W-1:0] res_best_r;

  // output register
  logic              out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_created_r;
  logic              out_full_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [DIST_W-1:0] out_best_r;

  // entry memory
  entry_t        mem [MAX_DRAGS];
  entry_t        rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  entry_t        mem_wd;

  // combinational helpers
  logic [COORD_BITS-1:0] dx, dy;
  logic [DW-1:0]         cand_dist;
  logic [CNTW-1:0]       pend_next;
  logic                  pend_last;
  logic [CNTW-1:0]       keep_nxt;
  logic                  cont_match;
  logic                  can_add;
  logic [CW-1:0]         best_ext;
  logic [CW-1:0]         maxd_ext;
  logic [DIST_W-1:0]     best_sat;
  logic [IW+SLOT_W-1:0]  slot_wide;
  logic [CNTW+COUNT_W-1:0] count_wide;
  entry_t                new_ent;
  entry_t                upd_ent;
  entry_t                ui_ent;

  assign in_ready = (state_r == S_IDLE);
  assign rd_addr  = rd_idx_r[IW-1:0];

  // distance of the entry read back to the previous point
  assign dx   = (rd_data_r.last_x > prev_x_r) ? rd_data_r.last_x - prev_x_r
                                              : prev_x_r - rd_data_r.last_x;
  assign dy   = (rd_data_r.last_y > prev_y_r) ? rd_data_r.last_y - prev_y_r
                                              : prev_y_r - rd_data_r.last_y;
  assign cand_dist = DW'(dx) + DW'(dy);

  // walk bookkeeping
  assign pend_next = CNTW'(pend_idx_r) + CNTW'(1);
  assign pend_last = pend_r && (pend_next == held_count_r);
  assign keep_nxt  = (pend_r && rd_data_r.pressed) ? keep_r + CNTW'(1) : keep_r;

  // update decision
  assign best_ext   = CW'(best_d_r);
  assign maxd_ext   = CW'(max_distance_r);
  assign cont_match = (held_count_r != '0) && (!pressed_r || (best_ext <= maxd_ext));
  assign can_add    = (held_count_r < CNTW'(MAX_DRAGS));
  assign best_sat   = (held_count_r == '0 || best_ext > CW'(DIST_SAT)) ? DIST_SAT
                                                                      : best_ext[DIST_W-1:0];

  // entry images to write back
  always_comb begin
    new_ent         = '0;
    new_ent.start_x = loc_x_r;
    new_ent.start_y = loc_y_r;
    new_ent.last_x  = loc_x_r;
    new_ent.last_y  = loc_y_r;
    new_ent.pressed = pressed_r;
    new_ent.fresh   = 1'b1;
    new_ent.buttons = buttons_r;
    new_ent.ui_flag = 1'b0;

    upd_ent         = best_ent_r;
    upd_ent.last_x  = loc_x_r;
    upd_ent.last_y  = loc_y_r;
    upd_ent.pressed = pressed_r;
    upd_ent.buttons = buttons_r;
    upd_ent.fresh   = 1'b0;

    ui_ent          = rd_data_r;
    ui_ent.ui_flag  = ui_value_r;
  end

  // memory write selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = new_ent;
    priority if (state_r == S_SCAN && pend_r && kind_r == K_DROP) begin
      mem_we = rd_data_r.pressed;
      mem_wa = keep_r[IW-1:0];
      mem_wd = rd_data_r;
    end else if (state_r == S_SCAN && pend_r && kind_r == K_SET_UI) begin
      mem_we = 1'b1;
      mem_wa = pend_idx_r;
      mem_wd = ui_ent;
    end else if (state_r == S_FINISH && cont_match) begin
      mem_we = 1'b1;
      mem_wa = best_idx_r;
      mem_wd = upd_ent;
    end else if (state_r == S_FINISH && can_add) begin
      mem_we = 1'b1;
      mem_wa = held_count_r[IW-1:0];
      mem_wd = new_ent;
    end else begin
      mem_we = 1'b0;
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_distance_r <= MAXD_RESET;
    end else if (cfg_wr_en) begin
      max_distance_r <= cfg_wr_data;
    end
  end

  // result fields masked to the port widths
  assign slot_wide  = {{SLOT_W{1'b0}}, res_slot_r};
  assign count_wide = {{COUNT_W{1'b0}}, held_count_r};

  // sequencer, table count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      held_count_r <= '0;
      rd_idx_r     <= '0;
      pend_r       <= 1'b0;
      keep_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // result taken and nothing new to load this cycle
      if (state_r != S_DONE && out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r        <= kind_t'(in_kind);
            prev_x_r      <= in_prev_x;
            prev_y_r      <= in_prev_y;
            loc_x_r       <= in_loc_x;
            loc_y_r       <= in_loc_y;
            pressed_r     <= in_is_pressed;
            buttons_r     <= in_button_mask;
            ui_value_r    <= in_ui_value;
            rd_idx_r      <= '0;
            pend_r        <= 1'b0;
            keep_r        <= '0;
            res_slot_r    <= '0;
            res_created_r <= 1'b0;
            res_full_r    <= 1'b0;
            res_best_r    <= '0;
            unique case (kind_t'(in_kind))
              K_CLEAR: begin
                held_count_r <= '0;
                state_r      <= S_DONE;
              end
              K_UPDATE: begin
                state_r <= (held_count_r == '0) ? S_FINISH : S_SCAN;
              end
              default: begin
                state_r <= (held_count_r == '0) ? S_DONE : S_SCAN;
              end
            endcase
          end
        end

        S_SCAN: begin
          // issue the next read
          if (rd_idx_r < held_count_r) begin
            rd_idx_r   <= rd_idx_r + CNTW'(1);
            pend_r     <= 1'b1;
            pend_idx_r <= rd_idx_r[IW-1:0];
          end else begin
            pend_r <= 1'b0;
          end
          // handle the entry read last cycle
          if (pend_r) begin
            if (kind_r == K_UPDATE && (pend_idx_r == '0 || cand_dist < best_d_r)) begin
              best_d_r   <= cand_dist;
              best_idx_r <= pend_idx_r;
              best_ent_r <= rd_data_r;
            end
            keep_r <= keep_nxt;
          end
          // last entry handled, no read is issued alongside it
          if (pend_last) begin
            if (kind_r == K_UPDATE) begin
              state_r <= S_FINISH;
            end else begin
              if (kind_r == K_DROP) begin
                held_count_r <= keep_nxt;
              end
              state_r <= S_DONE;
            end
          end
        end

        S_FINISH: begin
          res_best_r <= best_sat;
          if (cont_match) begin
            res_slot_r <= best_idx_r;
          end else if (can_add) begin
            res_slot_r    <= held_count_r[IW-1:0];
            res_created_r <= 1'b1;
            held_count_r  <= held_count_r + CNTW'(1);
          end else begin
            res_full_r <= 1'b1;
          end
          state_r <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_slot_r    <= slot_wide[SLOT_W-1:0];
            out_created_r <= res_created_r;
            out_full_r    <= res_full_r;
            out_count_r   <= count_wide[COUNT_W-1:0];
            out_best_r    <= res_best_r;
            state_r       <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_slot          = out_slot_r;
  assign out_created       = out_created_r;
  assign out_table_full    = out_full_r;
  assign out_entry_count   = out_count_r;
  assign out_best_distance = out_best_r;

  // table never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r <= CNTW'(MAX_DRAGS))
    else $error("held count exceeds table depth");

  // compaction never writes past the entry it has read
  a_keep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (keep_r <= rd_idx_r))
    else $error("compaction write index ahead of read index");

  // a pending read only exists during a walk
  a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_SCAN))
    else $error("pending read outside of walk");

  // an accepted transaction closes the input until its result is formed
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  // an appended entry is never also reported as table full
  a_created_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_created_r && out_full_r))
    else $error("created and table_full both set");

endmodule
